/* hdl/vs_pkg.sv */
package vs_pkg;

	// default size of the entry store, log2 of the entry count
	localparam int DEPTH_LOG2_DEF = 10;

	// fixed field widths
	localparam int OP_W     = 2;
	localparam int TYPE_W   = 3;
	localparam int DATA_W   = 32;
	localparam int COUNT_W  = 32;
	localparam int INDEX_W  = 16;
	localparam int ERR_W    = 3;
	localparam int DEPTH_W  = 11;
	localparam int LIMIT_W  = 11;
	localparam int ENTRY_W  = TYPE_W + DATA_W;

	// capacity limit after reset
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

	// operation codes
	localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
	localparam logic [OP_W-1:0] OP_POP  = 2'd1;
	localparam logic [OP_W-1:0] OP_POPN = 2'd2;
	localparam logic [OP_W-1:0] OP_PEEK = 2'd3;

	// error codes
	localparam logic [ERR_W-1:0] ERR_NONE  = 3'd0;
	localparam logic [ERR_W-1:0] ERR_DEPTH = 3'd1;
	localparam logic [ERR_W-1:0] ERR_LIMIT = 3'd2;
	localparam logic [ERR_W-1:0] ERR_POP   = 3'd3;
	localparam logic [ERR_W-1:0] ERR_POPN  = 3'd4;

	// one request
	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [TYPE_W-1:0]  push_type;
		logic [DATA_W-1:0]  push_data;
		logic [COUNT_W-1:0] pop_count;
		logic [INDEX_W-1:0] peek_index;
	} req_t;

	// one response
	typedef struct packed {
		logic [TYPE_W-1:0]  read_type;
		logic [DATA_W-1:0]  read_data;
		logic [ERR_W-1:0]   error_code;
		logic [DEPTH_W-1:0] depth_now;
	} rsp_t;

	// response fields known at issue, completed by the memory read data
	typedef struct packed {
		logic               use_data;
		logic [ERR_W-1:0]   err;
		logic [DEPTH_W-1:0] depth;
	} info_t;

endpackage

/* hdl/vs_ram.sv */
module vs_ram #(
	parameter int WIDTH      = 35,
	parameter int ADDR_W     = 10
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [(1 << ADDR_W)];
	logic [WIDTH-1:0] rdata_q;

	// one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hdl/vs_ctrl.sv */
module vs_ctrl #(
	parameter int DEPTH_LOG2 = vs_pkg::DEPTH_LOG2_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  vs_pkg::req_t                 req,
	input  logic                         cfg_wr_en,
	input  logic [vs_pkg::LIMIT_W-1:0]   cfg_wr_data,
	output logic                         ram_we,
	output logic [DEPTH_LOG2-1:0]        ram_waddr,
	output logic [vs_pkg::ENTRY_W-1:0]   ram_wdata,
	output logic                         ram_re,
	output logic [DEPTH_LOG2-1:0]        ram_raddr,
	output vs_pkg::info_t                info
);
	import vs_pkg::*;

	localparam int AW = DEPTH_LOG2;
	localparam int CW = AW + 1;
	localparam int GW = (AW + 2 > LIMIT_W) ? AW + 2 : LIMIT_W;
	localparam logic [GW-1:0] DEPTH_G = GW'(1) << AW;

	logic [CW-1:0]      count_q, count_d;
	logic [AW-1:0]      mask_q, mask_d;
	logic [CW-1:0]      fill_q, fill_d;
	logic [LIMIT_W-1:0] limit_q;

	logic [CW-1:0]      cap;
	logic               full;
	logic [GW-1:0]      grown;
	logic               over_depth;
	logic               over_limit;
	logic               we;
	logic               re;
	logic [AW-1:0]      waddr;
	logic [AW-1:0]      raddr;
	logic [ERR_W-1:0]   err;
	logic               is_read;

	// capacity and growth checks
	assign cap        = CW'(mask_q) + CW'(1);
	assign full       = count_q >= cap;
	assign grown      = GW'(cap) << 1;
	assign over_depth = grown > DEPTH_G;
	assign over_limit = grown > GW'(limit_q);

	// next state and memory command for the request
	always_comb begin
		count_d = count_q;
		mask_d  = mask_q;
		fill_d  = fill_q;
		we      = 1'b0;
		re      = 1'b0;
		waddr   = count_q[AW-1:0];
		raddr   = '0;
		err     = ERR_NONE;
		is_read = 1'b0;
		case (req.op)
			OP_PUSH: begin
				we = 1'b1;
				if (full && over_depth) begin
					err   = ERR_DEPTH;
					waddr = '0;
				end else if (full && over_limit) begin
					err   = ERR_LIMIT;
					waddr = '0;
				end else begin
					if (full) begin
						mask_d = AW'((mask_q << 1) | AW'(1));
					end
					count_d = count_q + CW'(1);
					if (count_q == fill_q) begin
						fill_d = count_q + CW'(1);
					end
				end
			end
			OP_POP: begin
				re      = 1'b1;
				is_read = 1'b1;
				if (count_q == '0) begin
					err = ERR_POP;
				end else begin
					count_d = count_q - CW'(1);
					raddr   = count_d[AW-1:0];
				end
			end
			OP_POPN: begin
				if (COUNT_W'(count_q) < req.pop_count) begin
					err     = ERR_POPN;
					count_d = '0;
				end else begin
					count_d = count_q - CW'(req.pop_count);
				end
			end
			OP_PEEK: begin
				re      = 1'b1;
				is_read = 1'b1;
				raddr   = req.peek_index[AW-1:0] & mask_q;
			end
			default: begin
				err = ERR_NONE;
			end
		endcase
	end

	// memory command, entries at or above the fill mark read as zero
	assign ram_we        = accept && we;
	assign ram_waddr     = waddr;
	assign ram_wdata     = {req.push_type, req.push_data};
	assign ram_re        = accept && re;
	assign ram_raddr     = raddr;
	assign info.use_data = is_read && (CW'(raddr) < fill_q);
	assign info.err      = err;
	assign info.depth    = DEPTH_W'(count_d);

	// stack pointer, capacity mask, fill mark and limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			mask_q  <= '0;
			fill_q  <= '0;
			limit_q <= LIMIT_RESET;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (accept) begin
				count_q <= count_d;
				mask_q  <= mask_d;
				fill_q  <= fill_d;
			end
		end
	end

endmodule

/* hdl/vs_resp.sv */
module vs_resp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  vs_pkg::info_t              info,
	input  logic [vs_pkg::ENTRY_W-1:0] rdata,
	output logic                       req_ready,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output vs_pkg::rsp_t               rsp
);
	import vs_pkg::*;

	logic          valid_s1;
	info_t         info_s1;
	logic          out_valid_q;
	rsp_t          out_q;
	logic          move;
	logic [ENTRY_W-1:0] entry;

	// stage one advances into the output register when it is free or draining
	assign move      = valid_s1 && (!out_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || move;
	assign entry     = info_s1.use_data ? rdata : '0;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1 <= info;
		end
		if (move) begin
			out_q.read_type  <= entry[ENTRY_W-1:DATA_W];
			out_q.read_data  <= entry[DATA_W-1:0];
			out_q.error_code <= info_s1.err;
			out_q.depth_now  <= info_s1.depth;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

/* hdl/vm_value_stack.sv */
// Typed value stack with a growable power-of-two capacity.
// Request channel: req_valid / req_ready with req (op, push value, pop count,
// peek index). Response channel: rsp_valid / rsp_ready with rsp (read type and
// data, error code, depth after the request). Every request gives one response.
// The capacity limit is written through cfg_wr_en / cfg_wr_data; the user must
// do so only while idle, which the block does not enforce. A response passes
// through stage one, with the registered store read, then the output register.
// Throughput: one request per cycle while the receiver keeps up; the entry store
// has one write and one read port, and each request uses at most one of them.
// The stack pointer and capacity are updated at accept, so back-to-back
// requests see each other's effects without forwarding.
// Reset clears the pointer, sets capacity to one and the limit to 1024. The
// store itself is not swept: a fill mark makes never-written entries read as
// zero, so the block takes requests in the first cycle after reset.
// When the receiver stalls, one response waits in the output register and one
// more in stage one; req_ready then drops until the output drains.
module vm_value_stack #(
	parameter int DEPTH_LOG2 = vs_pkg::DEPTH_LOG2_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_ready,
	input  vs_pkg::req_t             req,
	output logic                     rsp_valid,
	input  logic                     rsp_ready,
	output vs_pkg::rsp_t             rsp,
	input  logic                     cfg_wr_en,
	input  logic [vs_pkg::LIMIT_W-1:0] cfg_wr_data
);
	import vs_pkg::*;

	logic                  accept;
	logic                  ram_we;
	logic [DEPTH_LOG2-1:0] ram_waddr;
	logic [ENTRY_W-1:0]    ram_wdata;
	logic                  ram_re;
	logic [DEPTH_LOG2-1:0] ram_raddr;
	logic [ENTRY_W-1:0]    ram_rdata;
	info_t                 info;

	assign accept = req_valid && req_ready;

	// stack state and memory command
	vs_ctrl #(
		.DEPTH_LOG2 (DEPTH_LOG2)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.req         (req),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr),
		.info        (info)
	);

	// entry store
	vs_ram #(
		.WIDTH  (ENTRY_W),
		.ADDR_W (DEPTH_LOG2)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// response stage and output register
	vs_resp u_resp (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.info      (info),
		.rdata     (ram_rdata),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

/* hdl/vs_checker.sv */
module vs_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         req_valid,
	input logic         req_ready,
	input vs_pkg::req_t req,
	input logic         rsp_valid,
	input logic         rsp_ready,
	input vs_pkg::rsp_t rsp
);
	import vs_pkg::*;

	// a stalled response holds
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// error code stays within the defined set
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.error_code <= ERR_POPN)
		else $error("undefined error code");

	// underflow errors leave the stack empty
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.error_code == ERR_POP || rsp.error_code == ERR_POPN)
		|-> rsp.depth_now == '0)
		else $error("underflow with nonzero depth");

	// push errors return no read data
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.error_code == ERR_DEPTH || rsp.error_code == ERR_LIMIT)
		|-> rsp.read_type == '0 && rsp.read_data == '0)
		else $error("push error with read data");

	// a request accepted into an empty pipe raises rsp_valid after stage one and the output register
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && !rsp_valid |=> ##1 rsp_valid)
		else $error("missing response");

endmodule

bind vm_value_stack vs_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

/* sim/vs_stack_checker.sv */
`timescale 1ns / 1ps

module vs_stack_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	input  logic                       req_ready,
	input  vs_pkg::req_t               req,
	input  logic                       rsp_valid,
	input  logic                       rsp_ready,
	input  vs_pkg::rsp_t               rsp,
	input  logic                       cfg_wr_en,
	input  logic [vs_pkg::LIMIT_W-1:0] cfg_wr_data,
	output int                         mismatch_count,
	output int                         pending
);
	import vs_pkg::*;

	localparam int STORE_LOG2 = DEPTH_LOG2_DEF;
	localparam int STORE_SIZE = 1 << STORE_LOG2;

	// shadow copy of the stack
	logic [ENTRY_W-1:0]    stack_mem [STORE_SIZE];
	logic [DEPTH_W-1:0]    depth_cnt;
	logic [STORE_LOG2-1:0] cap_mask;
	logic [LIMIT_W-1:0]    cap_limit;

	rsp_t expected_rsps[$];
	rsp_t predicted;
	rsp_t oldest;

	// apply one request to the shadow stack and return its response
	function automatic rsp_t advance_stack(input req_t item);
		logic [ENTRY_W-1:0] word;
		logic [ERR_W-1:0]   err;
		int unsigned        cap;
		rsp_t               result;
		word = '0;
		err = ERR_NONE;
		case (item.op)
			OP_PUSH: begin
				cap = int'(cap_mask) + 1;
				// full: try to double the capacity
				if (int'(depth_cnt) >= cap) begin
					if (2 * cap > STORE_SIZE)
						err = ERR_DEPTH;
					else if (2 * cap > int'(cap_limit))
						err = ERR_LIMIT;
					else
						cap_mask = {cap_mask[STORE_LOG2-2:0], 1'b1};
				end
				// a refused growth lands the value in the bottom entry
				if (err != ERR_NONE) begin
					stack_mem[0] = {item.push_type, item.push_data};
				end else begin
					stack_mem[depth_cnt[STORE_LOG2-1:0]] = {item.push_type, item.push_data};
					depth_cnt = depth_cnt + 1'b1;
				end
			end
			OP_POP: begin
				if (depth_cnt == '0) begin
					err = ERR_POP;
					word = stack_mem[0];
				end else begin
					depth_cnt = depth_cnt - 1'b1;
					word = stack_mem[depth_cnt[STORE_LOG2-1:0]];
				end
			end
			OP_POPN: begin
				if (depth_cnt < item.pop_count) begin
					err = ERR_POPN;
					depth_cnt = '0;
				end else begin
					depth_cnt = depth_cnt - item.pop_count[DEPTH_W-1:0];
				end
			end
			default: begin
				word = stack_mem[item.peek_index[STORE_LOG2-1:0] & cap_mask];
			end
		endcase
		result.read_type = word[ENTRY_W-1:DATA_W];
		result.read_data = word[DATA_W-1:0];
		result.error_code = err;
		result.depth_now = depth_cnt;
		return result;
	endfunction

	task automatic check_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (got !== want) begin
			$error("%s expected %0h got %0h", name, want, got);
			mismatch_count++;
		end
	endtask

	// watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STORE_SIZE; i++)
				stack_mem[i] = '0;
			depth_cnt = '0;
			cap_mask = '0;
			cap_limit = LIMIT_RESET;
			expected_rsps.delete();
			mismatch_count = 0;
			pending = 0;
		end else begin
			// register write
			if (cfg_wr_en)
				cap_limit = cfg_wr_data;
			// predict on each accepted request
			if (req_valid && req_ready) begin
				predicted = advance_stack(req);
				expected_rsps.push_back(predicted);
			end
			// compare each accepted response with the oldest prediction
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					$error("response with no request outstanding");
					mismatch_count++;
				end else begin
					oldest = expected_rsps.pop_front();
					check_field("read_type", DATA_W'(oldest.read_type),
						DATA_W'(rsp.read_type));
					check_field("read_data", oldest.read_data, rsp.read_data);
					check_field("error_code", DATA_W'(oldest.error_code),
						DATA_W'(rsp.error_code));
					check_field("depth_now", DATA_W'(oldest.depth_now),
						DATA_W'(rsp.depth_now));
				end
			end
			pending = expected_rsps.size();
		end
	end

endmodule

/* sim/vm_value_stack_test.sv */
`timescale 1ns / 1ps

module vm_value_stack_test;
	import vs_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int FILL_TARGET = 1030;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_ready;
	req_t               req = '0;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	rsp_t               rsp;
	logic               cfg_wr_en = 1'b0;
	logic [LIMIT_W-1:0] cfg_wr_data = '0;

	int   mismatch_count;
	int   pending;
	int   idle_cycles = 0;
	int   net_pushes;
	int   pick;
	bit   calm = 1'b0;
	req_t fill_item;

	vm_value_stack dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	vs_stack_checker stack_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.req           (req),
		.rsp_valid     (rsp_valid),
		.rsp_ready     (rsp_ready),
		.rsp           (rsp),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.mismatch_count(mismatch_count),
		.pending       (pending)
	);

	always #5 clk = ~clk;

	// response side stalls at random except in calm stretches
	always @(negedge clk) begin
		rsp_ready <= calm || ($urandom_range(0, 99) >= 33);
	end

	// give up when nothing moves for too long
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic req_t make_request(input logic [OP_W-1:0] op,
			input logic [TYPE_W-1:0] ptype, input logic [DATA_W-1:0] pdata,
			input logic [COUNT_W-1:0] pcount, input logic [INDEX_W-1:0] pidx);
		req_t item;
		item.op = op;
		item.push_type = ptype;
		item.push_data = pdata;
		item.pop_count = pcount;
		item.peek_index = pidx;
		return item;
	endfunction

	// random request; wide pop counts only when asked for
	function automatic req_t random_request(input int push_pct, input bit wide_counts);
		req_t item;
		item.push_type = TYPE_W'($urandom_range(0, 7));
		item.push_data = $urandom;
		if (wide_counts && $urandom_range(0, 3) == 0)
			item.pop_count = $urandom;
		else
			item.pop_count = COUNT_W'($urandom_range(0, 3));
		item.peek_index = INDEX_W'($urandom_range(0, 16'hffff));
		if ($urandom_range(0, 99) < push_pct) begin
			item.op = OP_PUSH;
		end else begin
			case ($urandom_range(0, 2))
				0: item.op = OP_POP;
				1: item.op = OP_POPN;
				default: item.op = OP_PEEK;
			endcase
		end
		return item;
	endfunction

	// one request, with a random gap ahead of it outside calm stretches; returns at a falling edge
	task automatic send_request(input req_t item);
		if (!calm) begin
			while ($urandom_range(0, 99) < 33) begin
				req_valid <= 1'b0;
				@(negedge clk);
			end
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// drain, let the pipeline settle, then write the limit
	task automatic set_capacity_limit(input logic [LIMIT_W-1:0] lim);
		req_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (3)
			@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= lim;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic run_random(input int items, input int push_pct, input bit wide_counts);
		repeat (items)
			send_request(random_request(push_pct, wide_counts));
	endtask

	initial begin
		repeat (9)
			@(negedge clk);
		arst_n <= 1'b1;

		// empty stack under the reset limit
		send_request(make_request(OP_POP, '0, '0, '0, '0));
		send_request(make_request(OP_POPN, '0, '0, 32'd1, '0));
		send_request(make_request(OP_POPN, '0, '0, 32'd0, '0));
		send_request(make_request(OP_POPN, '0, '0, 32'hffff_ffff, '0));
		send_request(make_request(OP_PEEK, '0, '0, '0, 16'hffff));

		// limit of zero: the first entry still fits, growth is refused
		set_capacity_limit(11'd0);
		send_request(make_request(OP_PUSH, 3'd7, 32'hffff_ffff, '0, '0));
		send_request(make_request(OP_PUSH, 3'd5, 32'ha5a5_a5a5, '0, '0));
		send_request(make_request(OP_PEEK, '0, '0, '0, 16'hffff));
		send_request(make_request(OP_POP, '0, '0, '0, '0));
		send_request(make_request(OP_POP, '0, '0, '0, '0));

		// limit of one refuses growth the same way
		set_capacity_limit(11'd1);
		send_request(make_request(OP_PUSH, 3'd1, 32'h0000_0001, '0, '0));
		send_request(make_request(OP_PUSH, 3'd2, 32'h8000_0000, '0, '0));

		// limit of two: one growth, then refused
		set_capacity_limit(11'd2);
		send_request(make_request(OP_PUSH, 3'd3, 32'h1234_5678, '0, '0));
		send_request(make_request(OP_PUSH, 3'd4, 32'h0bad_f00d, '0, '0));
		send_request(make_request(OP_PEEK, '0, '0, '0, 16'hfffe));
		send_request(make_request(OP_PEEK, '0, '0, '0, 16'h0001));
		send_request(make_request(OP_POPN, '0, '0, 32'd2, '0));
		send_request(make_request(OP_POPN, '0, '0, 32'd0, '0));

		// random mixes under small limits
		set_capacity_limit(11'd3);
		run_random(12, 55, 1'b1);
		set_capacity_limit(LIMIT_W'($urandom_range(5, 40)));
		run_random(12, 60, 1'b1);

		// fill to full depth and push past it, first stretch without gaps
		set_capacity_limit(11'd1024);
		net_pushes = 0;
		while (net_pushes < FILL_TARGET) begin
			calm <= (net_pushes < 400);
			pick = $urandom_range(0, 99);
			if (pick < 98) begin
				fill_item = random_request(100, 1'b0);
				net_pushes++;
			end else if (pick < 99) begin
				fill_item = random_request(0, 1'b0);
				fill_item.op = OP_PEEK;
			end else begin
				fill_item = make_request(OP_POPN, '0, '0, '0, '0);
			end
			send_request(fill_item);
		end
		calm <= 1'b0;

		// full capacity under the widest and the narrowest limit
		set_capacity_limit(11'd2047);
		run_random(12, 45, 1'b1);
		set_capacity_limit(11'd0);
		run_random(8, 50, 1'b1);

		// wait for the last responses
		req_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (10)
			@(negedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* sim.f */
hdl/vs_pkg.sv
hdl/vs_ram.sv
hdl/vs_ctrl.sv
hdl/vs_resp.sv
hdl/vm_value_stack.sv
hdl/vs_checker.sv
sim/vs_stack_checker.sv
sim/vm_value_stack_test.sv
